[hdl/bst_pkg.sv]
// Shared types and constants for the bencode stream tokenizer.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
package bst_pkg;

	// Container stack depth and derived widths
	localparam int STACK_DEPTH = 10;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int LEVEL_W     = 4;
	localparam int VALUE_W     = 32;
	localparam int LEN_W       = 31;
	localparam int ACC_EXT_W   = VALUE_W + 4;

	// Configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_MAX_STR_LEN = 1'b0;
	localparam logic [LEN_W-1:0] MAX_STR_LEN_RST = {LEN_W{1'b1}};

	// Magnitude limits for a digit run
	localparam logic [ACC_EXT_W-1:0] LIMIT_POS = ACC_EXT_W'(32'h7FFF_FFFF);
	localparam logic [ACC_EXT_W-1:0] LIMIT_NEG = ACC_EXT_W'(32'h8000_0000);

	// Characters of the encoding
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_D     = 8'h64;

	typedef enum logic [2:0] {
		MODE_VALUE      = 3'd0,
		MODE_INT_SIGN   = 3'd1,
		MODE_INT_FIRST  = 3'd2,
		MODE_INT_DIGITS = 3'd3,
		MODE_LEN_DIGITS = 3'd4,
		MODE_LEN_FIRST  = 3'd5,
		MODE_STR_DATA   = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_INT  = 3'd1,
		EV_STR  = 3'd2,
		EV_BYTE = 3'd3,
		EV_LIST = 3'd4,
		EV_DICT = 3'd5,
		EV_END  = 3'd6,
		EV_DONE = 3'd7
	} event_t;

	typedef enum logic [3:0] {
		ERR_NONE      = 4'd0,
		ERR_DIGIT     = 4'd1,
		ERR_COLON     = 4'd2,
		ERR_E         = 4'd3,
		ERR_OVERFLOW  = 4'd4,
		ERR_UNDERFLOW = 4'd5,
		ERR_NEGATIVE  = 4'd6,
		ERR_LONG      = 4'd7,
		ERR_RANGE     = 4'd8,
		ERR_TRUNC     = 4'd9
	} err_t;

	// One result item
	typedef struct packed {
		event_t                     kind;
		logic signed [VALUE_W-1:0]  value;
		logic                       fin;
		logic [LEVEL_W-1:0]         level;
		logic                       in_dict;
		err_t                       err;
	} result_t;

endpackage

[hdl/bst_cfg.sv]
// APB-style register block holding the largest accepted string length.
// Depends on bst_pkg.
module bst_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bst_pkg::ADDR_W-1:0]  paddr,
	input  logic [bst_pkg::DATA_W-1:0]  pwdata,
	output logic [bst_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output logic [bst_pkg::LEN_W-1:0]   max_str_len
);

	logic [bst_pkg::LEN_W-1:0] max_str_len_q;
	logic                      reg_idx;
	logic                      wr_en;

	// Word index from the byte address
	assign reg_idx = paddr[bst_pkg::ADDR_W-1];
	assign wr_en   = psel & penable & pwrite & (reg_idx == bst_pkg::REG_MAX_STR_LEN);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_str_len_q <= bst_pkg::MAX_STR_LEN_RST;
		end else if (wr_en) begin
			max_str_len_q <= pwdata[bst_pkg::LEN_W-1:0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (reg_idx == bst_pkg::REG_MAX_STR_LEN) begin
			prdata = bst_pkg::DATA_W'(max_str_len_q);
		end
	end

	assign max_str_len = max_str_len_q;

endmodule

[hdl/bst_core.sv]
// Parser state and per-byte step logic: mode, digit accumulator, container stack, error latch.
// Depends on bst_pkg; produces one result item per accepted byte.
module bst_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  logic [7:0]                 data_byte,
	input  logic                       last,
	input  logic [bst_pkg::LEN_W-1:0]  max_str_len,
	output bst_pkg::result_t           res
);

	bst_pkg::mode_t                      mode_q, mode_d;
	logic [bst_pkg::VALUE_W-1:0]         acc_q, acc_d;
	logic                                neg_q, neg_d;
	logic [bst_pkg::LEN_W-1:0]           rem_q, rem_d, rem_dec;
	logic [bst_pkg::STACK_DEPTH-1:0]     stack_q, stack_d;
	logic [bst_pkg::SP_W-1:0]            sp_q, sp_d;
	bst_pkg::err_t                       err_q, err_d, err_new;

	logic                                is_dig;
	logic [3:0]                          digit;
	logic [bst_pkg::ACC_EXT_W-1:0]       acc_ext, acc_x10, limit;
	logic                                push;
	logic                                push_dict;
	bst_pkg::event_t                     kind;
	logic [bst_pkg::VALUE_W-1:0]         val;
	logic                                fin;
	logic                                top_dict;

	// Character class and next digit-run value
	assign is_dig  = (data_byte >= bst_pkg::CH_0) && (data_byte <= bst_pkg::CH_9);
	assign digit   = data_byte[3:0];
	assign acc_ext = bst_pkg::ACC_EXT_W'(acc_q);
	assign acc_x10 = (acc_ext << 3) + (acc_ext << 1) + bst_pkg::ACC_EXT_W'(digit);
	assign limit   = neg_q ? bst_pkg::LIMIT_NEG : bst_pkg::LIMIT_POS;
	assign rem_dec = (rem_q != '0) ? rem_q - 1'b1 : rem_q;

	// Step for one byte
	always_comb begin
		mode_d    = mode_q;
		acc_d     = acc_q;
		neg_d     = neg_q;
		rem_d     = rem_q;
		sp_d      = sp_q;
		push      = 1'b0;
		push_dict = 1'b0;
		err_new   = bst_pkg::ERR_NONE;
		kind      = bst_pkg::EV_NONE;
		val       = '0;
		fin       = 1'b0;

		if (err_q == bst_pkg::ERR_NONE) begin
			case (mode_q)
				bst_pkg::MODE_VALUE: begin
					if (data_byte == bst_pkg::CH_I) begin
						mode_d = bst_pkg::MODE_INT_SIGN;
						acc_d  = '0;
						neg_d  = 1'b0;
					end else if (data_byte == bst_pkg::CH_L || data_byte == bst_pkg::CH_D) begin
						if (sp_q >= bst_pkg::SP_W'(bst_pkg::STACK_DEPTH)) begin
							err_new = bst_pkg::ERR_OVERFLOW;
						end else begin
							push      = 1'b1;
							push_dict = (data_byte == bst_pkg::CH_D);
							sp_d      = sp_q + 1'b1;
							kind      = (data_byte == bst_pkg::CH_D) ? bst_pkg::EV_DICT
							                                         : bst_pkg::EV_LIST;
						end
					end else if (data_byte == bst_pkg::CH_E) begin
						if (sp_q == '0) begin
							err_new = bst_pkg::ERR_UNDERFLOW;
						end else begin
							sp_d = sp_q - 1'b1;
							kind = bst_pkg::EV_END;
						end
					end else if (is_dig) begin
						neg_d  = 1'b0;
						acc_d  = bst_pkg::VALUE_W'(digit);
						mode_d = bst_pkg::MODE_LEN_DIGITS;
					end else if (data_byte == bst_pkg::CH_MINUS) begin
						neg_d  = 1'b1;
						acc_d  = '0;
						mode_d = bst_pkg::MODE_LEN_FIRST;
					end else begin
						err_new = bst_pkg::ERR_DIGIT;
					end
				end
				bst_pkg::MODE_INT_SIGN: begin
					if (data_byte == bst_pkg::CH_MINUS) begin
						neg_d  = 1'b1;
						mode_d = bst_pkg::MODE_INT_FIRST;
					end else if (is_dig) begin
						acc_d  = bst_pkg::VALUE_W'(digit);
						mode_d = bst_pkg::MODE_INT_DIGITS;
					end else begin
						err_new = bst_pkg::ERR_DIGIT;
					end
				end
				bst_pkg::MODE_INT_FIRST: begin
					if (is_dig) begin
						acc_d  = bst_pkg::VALUE_W'(digit);
						mode_d = bst_pkg::MODE_INT_DIGITS;
					end else begin
						err_new = bst_pkg::ERR_DIGIT;
					end
				end
				bst_pkg::MODE_LEN_FIRST: begin
					if (is_dig) begin
						acc_d  = bst_pkg::VALUE_W'(digit);
						mode_d = bst_pkg::MODE_LEN_DIGITS;
					end else begin
						err_new = bst_pkg::ERR_DIGIT;
					end
				end
				bst_pkg::MODE_INT_DIGITS: begin
					if (is_dig) begin
						if (acc_x10 > limit) begin
							err_new = bst_pkg::ERR_RANGE;
						end else begin
							acc_d = acc_x10[bst_pkg::VALUE_W-1:0];
						end
					end else if (data_byte == bst_pkg::CH_E) begin
						kind   = bst_pkg::EV_INT;
						val    = neg_q ? ('0 - acc_q) : acc_q;
						acc_d  = '0;
						neg_d  = 1'b0;
						mode_d = bst_pkg::MODE_VALUE;
					end else begin
						err_new = bst_pkg::ERR_E;
					end
				end
				bst_pkg::MODE_LEN_DIGITS: begin
					if (is_dig) begin
						if (acc_x10 > limit) begin
							err_new = bst_pkg::ERR_RANGE;
						end else begin
							acc_d = acc_x10[bst_pkg::VALUE_W-1:0];
						end
					end else if (data_byte == bst_pkg::CH_COLON) begin
						if (neg_q && acc_q != '0) begin
							err_new = bst_pkg::ERR_NEGATIVE;
						end else if (acc_q > bst_pkg::VALUE_W'(max_str_len)) begin
							err_new = bst_pkg::ERR_LONG;
						end else begin
							kind   = bst_pkg::EV_STR;
							val    = acc_q;
							rem_d  = acc_q[bst_pkg::LEN_W-1:0];
							mode_d = (acc_q == '0) ? bst_pkg::MODE_VALUE
							                       : bst_pkg::MODE_STR_DATA;
							acc_d  = '0;
							neg_d  = 1'b0;
						end
					end else begin
						err_new = bst_pkg::ERR_COLON;
					end
				end
				bst_pkg::MODE_STR_DATA: begin
					kind  = bst_pkg::EV_BYTE;
					val   = bst_pkg::VALUE_W'(data_byte);
					rem_d = rem_dec;
					if (rem_dec == '0) begin
						fin    = 1'b1;
						mode_d = bst_pkg::MODE_VALUE;
					end
				end
				default: begin
					mode_d = bst_pkg::MODE_VALUE;
				end
			endcase

			// End of data: clean only between top-level values
			if (err_new == bst_pkg::ERR_NONE && last) begin
				if (mode_d == bst_pkg::MODE_VALUE && sp_d == '0) begin
					kind = bst_pkg::EV_DONE;
				end else begin
					err_new = bst_pkg::ERR_TRUNC;
				end
			end
			if (err_new != bst_pkg::ERR_NONE) begin
				kind = bst_pkg::EV_NONE;
				val  = '0;
				fin  = 1'b0;
			end
		end
	end

	assign err_d = (err_q != bst_pkg::ERR_NONE) ? err_q : err_new;

	// Stack write and innermost-container lookup after this byte
	always_comb begin
		stack_d  = stack_q;
		top_dict = 1'b0;
		for (int i = 0; i < bst_pkg::STACK_DEPTH; i++) begin
			if (push && sp_q == bst_pkg::SP_W'(i)) begin
				stack_d[i] = push_dict;
			end
		end
		for (int i = 0; i < bst_pkg::STACK_DEPTH; i++) begin
			if (sp_d == bst_pkg::SP_W'(i + 1)) begin
				top_dict = stack_d[i];
			end
		end
	end

	// Result item
	always_comb begin
		res.kind    = kind;
		res.value   = val;
		res.fin     = fin;
		res.level   = bst_pkg::LEVEL_W'(sp_d);
		res.in_dict = top_dict;
		res.err     = err_d;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bst_pkg::MODE_VALUE;
			acc_q  <= '0;
			neg_q  <= 1'b0;
			rem_q  <= '0;
			sp_q   <= '0;
			err_q  <= bst_pkg::ERR_NONE;
		end else if (fire) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			neg_q  <= neg_d;
			rem_q  <= rem_d;
			sp_q   <= sp_d;
			err_q  <= err_d;
		end
	end

	// Stack entries are only read once pushed
	always_ff @(posedge clk) begin
		if (fire) begin
			stack_q <= stack_d;
		end
	end

	// Depth never passes the stack size
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= bst_pkg::SP_W'(bst_pkg::STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	// A latched error never changes
	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != bst_pkg::ERR_NONE) |=> (err_q == $past(err_q)))
		else $error("latched error changed");

	// Depth frozen once an error is latched
	a_sp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != bst_pkg::ERR_NONE) |=> $stable(sp_q))
		else $error("depth moved after error");

	// String data mode always has bytes left to take
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == bst_pkg::MODE_STR_DATA) |-> (rem_q != '0))
		else $error("string data mode with no bytes remaining");

endmodule

[hdl/bst_out_reg.sv]
// Output register for result items; back-pressures the input while a result waits.
// Depends on bst_pkg.
module bst_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  bst_pkg::result_t  res_in,
	output logic              busy,
	output logic              out_valid,
	input  logic              out_stall,
	output bst_pkg::result_t  res_out
);

	logic             valid_q;
	bst_pkg::result_t res_q;

	// Full and not being drained this cycle
	assign busy = valid_q & out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule

[hdl/bencode_stream_tokenizer_top.sv]
// Top level of the bencode stream tokenizer: register block, parser core, output register.
// Depends on bst_pkg, bst_cfg, bst_core and bst_out_reg.
//
//  port group   direction  handshake            payload
//  input        in         in_valid/in_stall    data_byte, last
//  result       out        out_valid/out_stall  event_kind, value, final_string_byte,
//                                               nesting_level, in_dictionary, error_code
//  config       in         psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// One byte per clock while in_stall is low. The parser step sits between the state
// registers and the output register; an accepted byte's item shows in the next cycle.
// in_stall rises only while the output register holds an item and out_stall is high.
// Reset clears the parser state, the error latch and the output valid; the limit
// register returns to its largest value. The container stack needs no clearing.
module bencode_stream_tokenizer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        event_kind,
	output logic signed [bst_pkg::VALUE_W-1:0] value,
	output logic                              final_string_byte,
	output logic [bst_pkg::LEVEL_W-1:0]       nesting_level,
	output logic                              in_dictionary,
	output logic [3:0]                        error_code,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bst_pkg::ADDR_W-1:0]        paddr,
	input  logic [bst_pkg::DATA_W-1:0]        pwdata,
	output logic [bst_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);

	logic [bst_pkg::LEN_W-1:0] max_str_len;
	logic                      fire;
	logic                      busy;
	bst_pkg::result_t          res_new;
	bst_pkg::result_t          res_out;

	// Item accepted
	assign fire     = in_valid & ~busy;
	assign in_stall = busy;

	bst_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.max_str_len (max_str_len)
	);

	bst_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.data_byte   (data_byte),
		.last        (last),
		.max_str_len (max_str_len),
		.res         (res_new)
	);

	bst_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.res_in    (res_new),
		.busy      (busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_out)
	);

	// Result fields
	assign event_kind        = res_out.kind;
	assign value             = res_out.value;
	assign final_string_byte = res_out.fin;
	assign nesting_level     = res_out.level;
	assign in_dictionary     = res_out.in_dict;
	assign error_code        = res_out.err;

endmodule

[test/bst_event_monitor.sv]
// Monitor for the bencode stream tokenizer: watches the byte channel, the event channel
// and the config port, predicts every event item and compares it field by field.
// Depends on bst_pkg only.
module bst_event_monitor
	import bst_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [7:0]                 data_byte,
	input  logic                       last,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [2:0]                 event_kind,
	input  logic signed [VALUE_W-1:0]  value,
	input  logic                       final_string_byte,
	input  logic [LEVEL_W-1:0]         nesting_level,
	input  logic                       in_dictionary,
	input  logic [3:0]                 error_code,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [ADDR_W-1:0]          paddr,
	input  logic [DATA_W-1:0]          pwdata,
	output int                         failures,
	output int                         pending,
	output int                         events_compared
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ADDR_W-1:0] LIMIT_ADDR = ADDR_W'(4 * REG_MAX_STR_LEN);

	// predicted tokenizer state
	mode_t                  parse_state;
	logic [31:0]            acc;
	logic                   neg_sign;
	logic [LEN_W-1:0]       str_left;
	logic [STACK_DEPTH-1:0] dict_flags;
	int                     depth;
	err_t                   held_err;
	logic [LEN_W-1:0]       len_limit;

	result_t                expected_events[$];

	// append one decimal digit; 0 when the magnitude leaves the signed 32-bit range
	function automatic logic append_digit(input logic [7:0] b);
		longint unsigned grown;
		longint unsigned ceiling;
		ceiling = neg_sign ? 64'd2147483648 : 64'd2147483647;
		grown = longint'(acc) * 10 + longint'(b) - longint'(CH_0);
		if (grown > ceiling)
			return 1'b0;
		acc = grown[31:0];
		return 1'b1;
	endfunction

	// advance the predicted state by one byte and return the event item it causes
	function automatic result_t tokenize_byte(input logic [7:0] b, input logic is_last);
		result_t r;
		event_t  kind;
		logic [31:0] val;
		logic    fin;
		err_t    e;
		logic    is_dig;
		kind = EV_NONE;
		val = '0;
		fin = 1'b0;
		e = ERR_NONE;
		is_dig = (b >= CH_0) && (b <= CH_9);
		if (held_err == ERR_NONE) begin
			case (parse_state)
				MODE_VALUE: begin
					if (b == CH_I) begin
						parse_state = MODE_INT_SIGN;
						acc = '0;
						neg_sign = 1'b0;
					end else if (b == CH_L || b == CH_D) begin
						if (depth >= STACK_DEPTH) begin
							e = ERR_OVERFLOW;
						end else begin
							dict_flags[depth] = (b == CH_D);
							depth++;
							kind = (b == CH_D) ? EV_DICT : EV_LIST;
						end
					end else if (b == CH_E) begin
						if (depth == 0) begin
							e = ERR_UNDERFLOW;
						end else begin
							depth--;
							kind = EV_END;
						end
					end else if (is_dig) begin
						neg_sign = 1'b0;
						acc = 32'(b - CH_0);
						parse_state = MODE_LEN_DIGITS;
					end else if (b == CH_MINUS) begin
						neg_sign = 1'b1;
						acc = '0;
						parse_state = MODE_LEN_FIRST;
					end else begin
						e = ERR_DIGIT;
					end
				end
				MODE_INT_SIGN: begin
					if (b == CH_MINUS) begin
						neg_sign = 1'b1;
						parse_state = MODE_INT_FIRST;
					end else if (is_dig) begin
						acc = 32'(b - CH_0);
						parse_state = MODE_INT_DIGITS;
					end else begin
						e = ERR_DIGIT;
					end
				end
				MODE_INT_FIRST, MODE_LEN_FIRST: begin
					if (is_dig) begin
						acc = 32'(b - CH_0);
						if (parse_state == MODE_INT_FIRST)
							parse_state = MODE_INT_DIGITS;
						else
							parse_state = MODE_LEN_DIGITS;
					end else begin
						e = ERR_DIGIT;
					end
				end
				MODE_INT_DIGITS: begin
					if (is_dig) begin
						if (!append_digit(b))
							e = ERR_RANGE;
					end else if (b == CH_E) begin
						kind = EV_INT;
						val = neg_sign ? (32'd0 - acc) : acc;
						acc = '0;
						neg_sign = 1'b0;
						parse_state = MODE_VALUE;
					end else begin
						e = ERR_E;
					end
				end
				MODE_LEN_DIGITS: begin
					if (is_dig) begin
						if (!append_digit(b))
							e = ERR_RANGE;
					end else if (b == CH_COLON) begin
						if (neg_sign && acc != 0) begin
							e = ERR_NEGATIVE;
						end else if (acc > {1'b0, len_limit}) begin
							e = ERR_LONG;
						end else begin
							kind = EV_STR;
							val = acc;
							str_left = acc[LEN_W-1:0];
							if (acc == 0)
								parse_state = MODE_VALUE;
							else
								parse_state = MODE_STR_DATA;
							acc = '0;
							neg_sign = 1'b0;
						end
					end else begin
						e = ERR_COLON;
					end
				end
				default: begin
					// string payload: any byte value is data
					kind = EV_BYTE;
					val = {24'd0, b};
					if (str_left != 0)
						str_left--;
					if (str_left == 0) begin
						fin = 1'b1;
						parse_state = MODE_VALUE;
					end
				end
			endcase

			// last byte: clean end of data, or the data stops mid-value
			if (e == ERR_NONE && is_last) begin
				if (parse_state == MODE_VALUE && depth == 0)
					kind = EV_DONE;
				else
					e = ERR_TRUNC;
			end
			if (e != ERR_NONE) begin
				held_err = e;
				kind = EV_NONE;
				val = '0;
				fin = 1'b0;
			end
		end

		r.kind = kind;
		r.value = val;
		r.fin = fin;
		r.level = LEVEL_W'(depth);
		r.in_dict = (depth > 0) ? dict_flags[depth-1] : 1'b0;
		r.err = held_err;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			failures++;
			$display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	// handshakes sampled at the rising edge; results are popped before new bytes are queued
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			parse_state = MODE_VALUE;
			acc = '0;
			neg_sign = 1'b0;
			str_left = '0;
			dict_flags = '0;
			depth = 0;
			held_err = ERR_NONE;
			len_limit = MAX_STR_LEN_RST;
			expected_events.delete();
			failures = 0;
			pending = 0;
			events_compared = 0;
		end else begin
			// limit register write
			if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
				len_limit = pwdata[LEN_W-1:0];

			// event item out
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					failures++;
					$display("%0t: event item with none expected, actual kind %0d",
						$time, event_kind);
				end else begin
					want = expected_events.pop_front();
					events_compared++;
					compare_field("event_kind", 32'(want.kind), 32'(event_kind));
					compare_field("value", 32'(want.value), 32'(value));
					compare_field("final_string_byte", 32'(want.fin), 32'(final_string_byte));
					compare_field("nesting_level", 32'(want.level), 32'(nesting_level));
					compare_field("in_dictionary", 32'(want.in_dict), 32'(in_dictionary));
					compare_field("error_code", 32'(want.err), 32'(error_code));
				end
			end

			// byte item in
			if (in_valid && !in_stall)
				expected_events.push_back(tokenize_byte(data_byte, last));

			pending = expected_events.size();
		end
	end

endmodule

[test/bencode_stream_tokenizer_top_tb.sv]
// Testbench top for the bencode stream tokenizer: clock, reset, byte stimulus,
// receiver stalls, limit register writes and the verdict.
// Depends on bst_pkg, bencode_stream_tokenizer_top and bst_event_monitor.
module bencode_stream_tokenizer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bst_pkg::*;

	localparam int CLK_HALF     = 2;
	localparam int RUN_LIMIT_NS = 2_000_000;
	localparam int HOLD_CYCLES  = 64;
	localparam int PHASE_BYTES  = 320;
	localparam int NUM_PHASES   = 6;
	localparam logic [ADDR_W-1:0] LIMIT_ADDR = ADDR_W'(4 * REG_MAX_STR_LEN);

	typedef struct packed {
		logic [7:0] data;
		logic       tail;
	} byte_item_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [7:0]                data_byte;
	logic                      last;
	logic                      out_valid;
	logic                      out_stall;
	logic [2:0]                event_kind;
	logic signed [VALUE_W-1:0] value;
	logic                      final_string_byte;
	logic [LEVEL_W-1:0]        nesting_level;
	logic                      in_dictionary;
	logic [3:0]                error_code;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [ADDR_W-1:0]         paddr;
	logic [DATA_W-1:0]         pwdata;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;

	int failures;
	int pending;
	int events_compared;

	byte_item_t       stream_q[$];
	int               bytes_sent;
	int               streams_sent;
	int               deepest;
	int               cfg_writes;
	logic             idle_on;
	int               hold_reqs;
	int               hold_seen;
	int               hold_left;
	logic [LEN_W-1:0] str_limit_now;
	err_t             final_err;

	bencode_stream_tokenizer_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte), .last(last),
		.out_valid(out_valid), .out_stall(out_stall), .event_kind(event_kind),
		.value(value), .final_string_byte(final_string_byte),
		.nesting_level(nesting_level), .in_dictionary(in_dictionary),
		.error_code(error_code),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	bst_event_monitor u_events (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte), .last(last),
		.out_valid(out_valid), .out_stall(out_stall), .event_kind(event_kind),
		.value(value), .final_string_byte(final_string_byte),
		.nesting_level(nesting_level), .in_dictionary(in_dictionary),
		.error_code(error_code),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.failures(failures), .pending(pending), .events_compared(events_compared)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// overall time limit
	initial begin
		#RUN_LIMIT_NS;
		$display("status: fail");
		$finish;
	end

	// receiver: random stalls while idling is on, none while it is off, or a long hold-off when one is requested
	initial begin
		hold_seen = 0;
		hold_left = 0;
		forever @(negedge clk) begin
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (!idle_on) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 25);
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		stream_q.push_back('{b, 1'b0});
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// flag the newest queued byte as the last of the data
	task automatic mark_end();
		byte_item_t it;
		it = stream_q.pop_back();
		it.tail = 1'b1;
		stream_q.push_back(it);
	endtask

	// integer: extremes, zero (signed or not), leading zeros, random magnitudes
	task automatic push_int();
		longint unsigned mag;
		logic neg;
		int r;
		r = $urandom_range(0, 99);
		neg = 1'($urandom_range(0, 1));
		if (r < 8) begin
			mag = 64'd2147483647;
			neg = 1'b0;
		end else if (r < 16) begin
			mag = 64'd2147483648;
			neg = 1'b1;
		end else if (r < 24) begin
			mag = 0;
		end else begin
			mag = longint'($urandom >> $urandom_range(1, 31));
		end
		push_byte(CH_I);
		if (neg)
			push_byte(CH_MINUS);
		if ($urandom_range(0, 99) < 15)
			repeat ($urandom_range(1, 2)) push_byte(CH_0);
		push_text($sformatf("%0d", mag));
		push_byte(CH_E);
	endtask

	// string within the current length limit, with random payload bytes
	task automatic push_str();
		int cap;
		int len;
		cap = (str_limit_now < 12) ? int'(str_limit_now) : 12;
		if (str_limit_now >= 40 && $urandom_range(0, 9) == 0)
			cap = 40;
		len = $urandom_range(0, cap);
		if (len == 0 && $urandom_range(0, 3) == 0)
			push_byte(CH_MINUS);
		if ($urandom_range(0, 99) < 10)
			push_byte(CH_0);
		push_text($sformatf("%0d", len));
		push_byte(CH_COLON);
		repeat (len) push_byte(8'($urandom_range(0, 255)));
	endtask

	// one well-formed run of values, all containers closed at the end
	task automatic build_stream(input int target);
		int depth;
		int r;
		int start;
		start = stream_q.size();
		depth = 0;
		while ((stream_q.size() - start) < target || depth > 0) begin
			r = $urandom_range(0, 99);
			if (depth > 0 && (r < 22 || (stream_q.size() - start) >= target)) begin
				push_byte(CH_E);
				depth--;
			end else if (depth < STACK_DEPTH && r < 50) begin
				push_byte($urandom_range(0, 1) ? CH_D : CH_L);
				depth++;
				if (depth > deepest)
					deepest = depth;
			end else if (r < 75) begin
				push_int();
			end else begin
				push_str();
			end
		end
		if ($urandom_range(0, 99) < 70)
			mark_end();
	endtask

	// one byte item: optional idle gap, then hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic t);
		if (idle_on && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last <= t;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		bytes_sent++;
		if (t)
			streams_sent++;
	endtask

	task automatic send_all();
		byte_item_t it;
		while (stream_q.size() > 0) begin
			it = stream_q.pop_front();
			send_byte(it.data, it.tail);
		end
	endtask

	// stop sending and wait until every predicted event item is out
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [DATA_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		str_limit_now = v[LEN_W-1:0];
		cfg_writes++;
	endtask

	// closing sequence that raises the given error code
	task automatic push_error(input err_t code);
		logic [7:0] b;
		case (code)
			ERR_DIGIT: begin
				if ($urandom_range(0, 1)) begin
					do b = 8'($urandom_range(0, 255));
					while (b == CH_I || b == CH_L || b == CH_D || b == CH_E ||
						b == CH_MINUS || (b >= CH_0 && b <= CH_9));
					push_byte(b);
				end else begin
					push_text("ie");
				end
			end
			ERR_COLON: begin
				do b = 8'($urandom_range(0, 255));
				while (b == CH_COLON || (b >= CH_0 && b <= CH_9));
				push_text("12");
				push_byte(b);
			end
			ERR_E: begin
				push_text("i42");
				push_byte(CH_COLON);
			end
			ERR_OVERFLOW: repeat (STACK_DEPTH + 1) push_byte($urandom_range(0, 1) ? CH_D : CH_L);
			ERR_UNDERFLOW: push_byte(CH_E);
			ERR_NEGATIVE: push_text("-7:");
			ERR_LONG: push_text($sformatf("%0d:", longint'(str_limit_now) + 1));
			ERR_RANGE: begin
				case ($urandom_range(0, 2))
					0: push_text("i2147483648e");
					1: push_text("i-2147483649e");
					default: push_text("2147483648:");
				endcase
			end
			default: begin
				push_text("li3");
				mark_end();
			end
		endcase
	endtask

	// stimulus
	initial begin
		logic [DATA_W-1:0] limit_val;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		last = 1'b0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_on = 1'b1;
		hold_reqs = 0;
		bytes_sent = 0;
		streams_sent = 0;
		deepest = 0;
		cfg_writes = 0;
		str_limit_now = MAX_STR_LEN_RST;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: signed zero integer, empty string, full-depth nesting, clean end
		push_text("i-0e");
		push_text("0:");
		for (int i = 0; i < STACK_DEPTH; i++)
			push_byte((i % 2) ? CH_D : CH_L);
		repeat (STACK_DEPTH) push_byte(CH_E);
		mark_end();
		deepest = STACK_DEPTH;
		send_all();

		// random well-formed streams under several length limits
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: limit_val = '0;
				1: limit_val = 32'h7FFF_FFFF;
				2: limit_val = 32'($urandom_range(1, 8));
				3: limit_val = $urandom;
				4: limit_val = 32'd1;
				default: limit_val = 32'hFFFF_FFFF;
			endcase
			drain();
			cfg_write(limit_val);
			// one phase runs with no idling on either side
			idle_on <= (p != 2);
			if (p == 3)
				hold_reqs <= hold_reqs + 1;
			while (stream_q.size() < PHASE_BYTES)
				build_stream($urandom_range(4, 40));
			send_all();
		end

		// closing error, then bytes the block must ignore
		drain();
		cfg_write(32'($urandom_range(0, 500)));
		final_err = err_t'(4'($urandom_range(1, 9)));
		push_error(final_err);
		repeat (20) stream_q.push_back('{8'($urandom), 1'($urandom_range(0, 1))});
		send_all();
		drain();

		$display("run covered %0d byte items in %0d terminated streams, %0d limit writes,",
			bytes_sent, streams_sent, cfg_writes);
		$display("  %0d event items compared, nesting up to %0d, closing error code %0d",
			events_compared, deepest, final_err);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
